[design/trtc_pkg.sv]
// ----------------------------------------------------------------------------
// TFTP read receive control: shared types and constants
// Packet codes, status codes, register indexes and the item structures used
// by every stage of the receive controller.
// ----------------------------------------------------------------------------
package trtc_pkg;

  // Packet opcodes and header size.
  localparam logic [15:0] OpcData  = 16'd3;
  localparam logic [15:0] OpcError = 16'd5;
  localparam logic [15:0] HdrBytes = 16'd4;

  // Transfer status codes.
  localparam logic [2:0] StRunning   = 3'd0;
  localparam logic [2:0] StComplete  = 3'd1;
  localparam logic [2:0] StBadBlock  = 3'd2;
  localparam logic [2:0] StServerErr = 3'd3;
  localparam logic [2:0] StBadOpcode = 3'd4;
  localparam logic [2:0] StNoRetries = 3'd5;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgRetryLimit   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDataBlockSize = 2'd1;

  // Reset values.
  localparam logic [7:0]  RetryLimitRst = 8'd5;
  localparam logic [15:0] BlockSizeRst  = 16'd512;
  localparam logic [15:0] FirstBlock    = 16'd1;

  typedef struct packed {
    logic        req_type;
    logic [15:0] packet_opcode;
    logic [15:0] packet_block;
    logic [15:0] packet_length;
  } in_item_t;

  typedef struct packed {
    logic        ack_now;
    logic [15:0] ack_block;
    logic        keep_payload;
    logic [15:0] payload_length;
    logic [2:0]  transfer_status;
    logic [15:0] server_error_code;
  } out_item_t;

  // Pipeline handshake between the stages.
  typedef struct packed {
    logic advance;   // result register may load this cycle
    logic s1_valid;  // input register holds an item
  } flow_t;

endpackage

[design/trtc_in_if.sv]
// ----------------------------------------------------------------------------
// TFTP read receive control: input channel
// Valid/ready channel carrying a packet header or a timeout tick.
// ----------------------------------------------------------------------------
interface trtc_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] packet_opcode;
  logic [15:0] packet_block;
  logic [15:0] packet_length;

  modport source (output valid, output req_type, output packet_opcode,
                  output packet_block, output packet_length, input ready);
  modport sink   (input valid, input req_type, input packet_opcode,
                  input packet_block, input packet_length, output ready);
endinterface

[design/trtc_out_if.sv]
// ----------------------------------------------------------------------------
// TFTP read receive control: result channel
// Valid/ready channel carrying one decision per received item.
// ----------------------------------------------------------------------------
interface trtc_out_if;
  logic        valid;
  logic        ready;
  logic        ack_now;
  logic [15:0] ack_block;
  logic        keep_payload;
  logic [15:0] payload_length;
  logic [2:0]  transfer_status;
  logic [15:0] server_error_code;

  modport source (output valid, output ack_now, output ack_block,
                  output keep_payload, output payload_length,
                  output transfer_status, output server_error_code,
                  input ready);
  modport sink   (input valid, input ack_now, input ack_block,
                  input keep_payload, input payload_length,
                  input transfer_status, input server_error_code,
                  output ready);
endinterface

[design/trtc_cfg_if.sv]
// ----------------------------------------------------------------------------
// TFTP read receive control: configuration write channel
// Valid/ready write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface trtc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [trtc_pkg::CfgIdxW-1:0]   index;
  logic [15:0]                    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[design/trtc_in_reg.sv]
// ----------------------------------------------------------------------------
// TFTP read receive control: input register
// Captures one item per transfer and holds it until the decision stage moves.
// ----------------------------------------------------------------------------
module trtc_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  trtc_in_if.sink            in_ch,
  input  logic               advance,
  output trtc_pkg::flow_t    flow,
  output trtc_pkg::in_item_t item
);

  logic               s1_valid_r;
  trtc_pkg::in_item_t item_r;
  logic               take;

  // The register empties whenever the result stage advances.
  assign in_ch.ready = !s1_valid_r || advance;
  assign take        = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.req_type      <= in_ch.req_type;
      item_r.packet_opcode <= in_ch.packet_opcode;
      item_r.packet_block  <= in_ch.packet_block;
      item_r.packet_length <= in_ch.packet_length;
    end
  end

  assign flow.advance  = advance;
  assign flow.s1_valid = s1_valid_r;
  assign item          = item_r;

endmodule

[design/trtc_core.sv]
// ----------------------------------------------------------------------------
// TFTP read receive control: decision core
// Holds the configuration and transfer state and decides each item's result.
// ----------------------------------------------------------------------------
module trtc_core (
  input  logic                clk,
  input  logic                rst_n,
  trtc_cfg_if.sink            cfg_ch,
  input  trtc_pkg::flow_t     flow,
  input  trtc_pkg::in_item_t  item,
  output trtc_pkg::out_item_t result
);

  logic [7:0]  retry_limit_r;
  logic [15:0] block_size_r;
  logic [15:0] expected_block_r, expected_block_nxt;
  logic [7:0]  retry_count_r, retry_count_nxt;
  logic [2:0]  end_status_r, end_status_nxt;
  logic [15:0] plen;
  logic        step;
  trtc_pkg::out_item_t res;

  assign cfg_ch.ready = 1'b1;
  assign step         = flow.s1_valid && flow.advance;
  assign plen         = item.packet_length - trtc_pkg::HdrBytes;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_limit_r <= trtc_pkg::RetryLimitRst;
      block_size_r  <= trtc_pkg::BlockSizeRst;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        trtc_pkg::CfgRetryLimit:    retry_limit_r <= cfg_ch.data[7:0];
        trtc_pkg::CfgDataBlockSize: block_size_r  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    res                = '0;
    expected_block_nxt = expected_block_r;
    retry_count_nxt    = retry_count_r;
    end_status_nxt     = end_status_r;
    if (end_status_r == trtc_pkg::StRunning) begin
      if (item.req_type) begin
        if (retry_count_r < retry_limit_r) begin
          // Nothing to re-acknowledge before the first block arrives.
          if (expected_block_r != trtc_pkg::FirstBlock) begin
            res.ack_now   = 1'b1;
            res.ack_block = expected_block_r - 16'd1;
          end
          retry_count_nxt = retry_count_r + 8'd1;
        end else begin
          end_status_nxt = trtc_pkg::StNoRetries;
        end
      end else if (item.packet_length < trtc_pkg::HdrBytes) begin
        retry_count_nxt = '0;
      end else if (item.packet_opcode == trtc_pkg::OpcData) begin
        if (item.packet_block == expected_block_r) begin
          res.ack_now        = 1'b1;
          res.ack_block      = item.packet_block;
          res.keep_payload   = 1'b1;
          res.payload_length = plen;
          if (plen < block_size_r) begin
            end_status_nxt = trtc_pkg::StComplete;
          end
          expected_block_nxt = expected_block_r + 16'd1;
          retry_count_nxt    = '0;
        end else if (item.packet_block < expected_block_r) begin
          res.ack_now     = 1'b1;
          res.ack_block   = item.packet_block;
          retry_count_nxt = '0;
        end else begin
          end_status_nxt = trtc_pkg::StBadBlock;
        end
      end else if (item.packet_opcode == trtc_pkg::OpcError) begin
        end_status_nxt        = trtc_pkg::StServerErr;
        res.server_error_code = item.packet_block;
      end else begin
        end_status_nxt = trtc_pkg::StBadOpcode;
      end
    end
    res.transfer_status = end_status_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_block_r <= trtc_pkg::FirstBlock;
      retry_count_r    <= '0;
      end_status_r     <= trtc_pkg::StRunning;
    end else if (step) begin
      expected_block_r <= expected_block_nxt;
      retry_count_r    <= retry_count_nxt;
      end_status_r     <= end_status_nxt;
    end
  end

  assign result = res;

  // A finished transfer never resumes or changes its status.
  a_end_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    end_status_r != trtc_pkg::StRunning |=> end_status_r == $past(end_status_r))
    else $error("end status changed after the transfer ended");

  // The expected block only ever moves forward by one.
  a_block_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && expected_block_r != $past(expected_block_r) |->
      expected_block_r == $past(expected_block_r) + 16'd1)
    else $error("expected block jumped");

  // A kept payload is always acknowledged with the block just expected.
  a_keep_ack: assert property (@(posedge clk) disable iff (!rst_n)
    flow.s1_valid && res.keep_payload |->
      res.ack_now && res.ack_block == expected_block_r)
    else $error("kept payload without matching acknowledgement");

  // Without a step, the expected block and the retry count hold.
  a_no_step_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(expected_block_r) && $stable(retry_count_r))
    else $error("transfer state moved without an item");

endmodule

[design/trtc_out_reg.sv]
// ----------------------------------------------------------------------------
// TFTP read receive control: result register
// Holds one result until the receiver takes it and drives the result channel.
// ----------------------------------------------------------------------------
module trtc_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                s1_valid,
  input  trtc_pkg::out_item_t result,
  output logic                advance,
  trtc_out_if.source          out_ch
);

  logic                out_valid_r;
  trtc_pkg::out_item_t out_item_r;

  assign advance = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_item_r <= result;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.ack_now           = out_item_r.ack_now;
  assign out_ch.ack_block         = out_item_r.ack_block;
  assign out_ch.keep_payload      = out_item_r.keep_payload;
  assign out_ch.payload_length    = out_item_r.payload_length;
  assign out_ch.transfer_status   = out_item_r.transfer_status;
  assign out_ch.server_error_code = out_item_r.server_error_code;

endmodule

[design/tftp_read_receive_control_top.sv]
// ----------------------------------------------------------------------------
// TFTP read receive control: top level
// Receive side of a TFTP read: decides acknowledgements, payload storage and
// the end of the transfer from packet headers and timeout ticks.
// ----------------------------------------------------------------------------
// Usage. Each transfer on in_ch carries either a received packet header
// (req_type 0: opcode, block number, total length) or a timeout tick
// (req_type 1). Every item yields exactly one result on out_ch, telling the
// surrounding logic whether to send an ACK and for which block, whether to
// store the payload, and the transfer status.
// An accepted item waits in the input register until the result register
// advances and loads its result, which is then offered on out_ch.
// Throughput is one item per cycle while out_ch is not stalled, with the
// single decision stage between the input and result registers.
// cfg_ch writes retry_limit (index 0) and data_block_size (index 1); it is
// always ready and should be written only while the block is idle.
// Reset restores a retry limit of five, a block size of 512, expects block 1
// with no retries counted and a running transfer; both channels are empty.
// When the receiver stalls, the result register holds and the input
// register takes at most one more item, after which in_ch drops ready.
// Once the transfer has ended, further items produce results that only
// repeat the final status.
// ----------------------------------------------------------------------------
module tftp_read_receive_control_top (
  input  logic       clk,
  input  logic       rst_n,
  trtc_in_if.sink    in_ch,
  trtc_out_if.source out_ch,
  trtc_cfg_if.sink   cfg_ch
);

  trtc_pkg::flow_t     flow;
  trtc_pkg::in_item_t  item;
  trtc_pkg::out_item_t result;
  logic                advance;

  // Input register: one held item, refilled as soon as the result stage moves.
  trtc_in_reg u_in_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .advance (advance),
    .flow    (flow),
    .item    (item)
  );

  // Decision logic and transfer state; state commits when the result loads.
  trtc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .flow   (flow),
    .item   (item),
    .result (result)
  );

  // Result register, which parts the receiver's stalls from the input side.
  trtc_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (flow.s1_valid),
    .result   (result),
    .advance  (advance),
    .out_ch   (out_ch)
  );

endmodule
